/* rtl/tcp_client_connection_tracker_unit_defines.svh */
// Assertion macros used by the tracker controller
`ifndef TCP_CLIENT_CONNECTION_TRACKER_UNIT_DEFINES_SVH
`define TCP_CLIENT_CONNECTION_TRACKER_UNIT_DEFINES_SVH

// implication checked each clock, muted in reset
`define TCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, muted in reset
`define TCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tct_pkg.sv */
`timescale 1ns / 1ps
package tct_pkg;
  localparam int ConnEntries = 16;
  localparam int IdxW = (ConnEntries > 1) ? $clog2(ConnEntries) : 1;

  localparam logic [2:0] ST_UNUSED = 3'd0;
  localparam logic [2:0] ST_OPENING = 3'd1;
  localparam logic [2:0] ST_ESTABLISHED = 3'd2;
  localparam logic [2:0] ST_FIN_OUT = 3'd3;
  localparam logic [2:0] ST_FIN_ACKED = 3'd4;
  localparam logic [2:0] ST_TIME_WAIT = 3'd5;
  localparam logic [2:0] ST_CLOSED = 3'd6;

  localparam logic [2:0] K_HEADER = 3'd0;
  localparam logic [2:0] K_ACCEPT = 3'd1;
  localparam logic [2:0] K_IGNORE = 3'd2;
  localparam logic [2:0] K_CSUM = 3'd3;
  localparam logic [2:0] K_SEQ = 3'd4;
  localparam logic [2:0] K_NOCONN = 3'd5;
  localparam logic [2:0] K_FULL = 3'd6;

  localparam logic [5:0] FL_ACK = 6'h10;
  localparam logic [5:0] FL_SYN = 6'h02;
  localparam logic [5:0] FL_FIN = 6'h01;

  localparam logic CFG_SEQ_BASE = 1'b0;
  localparam logic CFG_INIT_WIN = 1'b1;

  localparam logic [15:0] HDR_LEN = 16'd20;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EXEC, S_OUT1, S_OUT2
  } state_t;

  typedef struct packed {
    logic load;      // capture input item, start scan
    logic step;      // advance scan pointer
    logic exec;      // decide and write back
    logic out_ld1;   // first result into output register
    logic out_ld2;   // second result into output register
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic two_res;
  } sts_t;
endpackage

/* rtl/tct_datapath.sv */
`timescale 1ns / 1ps
module tct_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tct_pkg::cmd_t       cmd,
  output tct_pkg::sts_t       sts,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_op,
  input  logic [31:0]         in_local_addr,
  input  logic [15:0]         in_local_port,
  input  logic [31:0]         in_remote_addr,
  input  logic [15:0]         in_remote_port,
  input  logic [5:0]          in_seg_flags,
  input  logic [31:0]         in_rx_seq,
  input  logic [31:0]         in_rx_ack,
  input  logic [15:0]         in_segment_len,
  input  logic                in_checksum_ok,
  output logic [2:0]          out_kind,
  output logic [3:0]          out_conn_index,
  output logic [31:0]         out_tx_seq,
  output logic [31:0]         out_tx_ack,
  output logic [15:0]         out_tx_window,
  output logic [5:0]          out_tx_flags,
  output logic [2:0]          out_conn_status,
  output logic                out_last
);
  localparam int N = tct_pkg::ConnEntries;
  localparam int W = tct_pkg::IdxW;

  logic [31:0] seq_base_r;
  logic [15:0] init_win_r;

  logic [2:0]  st_r [N];
  logic [31:0] la_r [N];
  logic [31:0] ra_r [N];
  logic [15:0] lp_r [N];
  logic [15:0] rp_r [N];
  logic [31:0] sq_r [N];
  logic [31:0] ak_r [N];
  logic [15:0] wn_r [N];

  // captured item
  logic        op_r, cs_r;
  logic [31:0] ila_r, ira_r, rseq_r, rack_r;
  logic [15:0] ilp_r, irp_r, slen_r;
  logic [5:0]  fl_r;

  // one entry is examined per cycle
  logic [W-1:0] ptr_r;
  logic        hit_r, free_v_r;
  logic [W-1:0] hit_idx_r, free_idx_r;

  // second result held until first one goes
  logic [2:0]  k2_r, st2_r;
  logic [W-1:0] i2_r;
  logic        two_r;

  logic [W-1:0] pi;
  logic        match;
  assign pi = ptr_r;
  assign match = (st_r[pi] != tct_pkg::ST_UNUSED) && la_r[pi] == ila_r &&
                 lp_r[pi] == ilp_r && ra_r[pi] == ira_r && rp_r[pi] == irp_r;
  assign sts = tct_pkg::sts_t'{scan_done: (ptr_r == W'(N - 1)), two_res: two_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_base_r <= 32'd1;
      init_win_r <= 16'd1;
    end else if (cfg_we) begin
      if (cfg_index == tct_pkg::CFG_SEQ_BASE) seq_base_r <= cfg_wdata;
      else init_win_r <= cfg_wdata[15:0];
    end
  end

  // execution decision
  logic [W-1:0] ei;
  logic [2:0]  cur, nst, kind1, kind2;
  logic        wr_tuple, wr_sa, is_hdr2, res1_only;
  logic [31:0] nsq, nak, seq_p1;
  logic [15:0] nwn;
  logic        fa, fs, ff;

  always_comb begin
    fa = (fl_r & tct_pkg::FL_ACK) != 6'd0;
    fs = (fl_r & tct_pkg::FL_SYN) != 6'd0;
    ff = (fl_r & tct_pkg::FL_FIN) != 6'd0;
    ei = hit_r ? hit_idx_r : free_idx_r;
    cur = hit_r ? st_r[ei] : tct_pkg::ST_CLOSED;
    seq_p1 = sq_r[ei] + 32'd1;
    nst = cur;
    nsq = hit_r ? sq_r[ei] : seq_base_r + 32'(ei);
    nak = hit_r ? ak_r[ei] : 32'd0;
    nwn = hit_r ? wn_r[ei] : init_win_r;
    wr_tuple = 1'b0;
    wr_sa = 1'b0;
    is_hdr2 = 1'b0;
    res1_only = 1'b0;
    kind1 = tct_pkg::K_ACCEPT;
    kind2 = tct_pkg::K_ACCEPT;
    if (!op_r) begin
      if (!hit_r && !free_v_r) begin
        res1_only = 1'b1;
        kind1 = tct_pkg::K_FULL;
      end else begin
        wr_tuple = !hit_r;
        wr_sa = !hit_r;
        kind1 = tct_pkg::K_HEADER;
        if (cur == tct_pkg::ST_CLOSED && fl_r == tct_pkg::FL_SYN)
          nst = tct_pkg::ST_OPENING;
        else if (cur == tct_pkg::ST_ESTABLISHED &&
                 (fl_r == tct_pkg::FL_FIN || fl_r == (tct_pkg::FL_FIN | tct_pkg::FL_ACK)))
          nst = tct_pkg::ST_FIN_OUT;
      end
    end else if (!cs_r) begin
      res1_only = 1'b1;
      kind1 = tct_pkg::K_CSUM;
    end else if (!hit_r) begin
      res1_only = 1'b1;
      kind1 = tct_pkg::K_NOCONN;
    end else begin
      kind1 = tct_pkg::K_ACCEPT;
      case (cur)
        tct_pkg::ST_OPENING: begin
          if (!(fs && fa)) kind1 = tct_pkg::K_IGNORE;
          else if (rack_r != seq_p1) kind1 = tct_pkg::K_SEQ;
          else begin
            nsq = rack_r; nak = rseq_r + 32'd1; wr_sa = 1'b1;
            nst = tct_pkg::ST_ESTABLISHED; is_hdr2 = 1'b1;
          end
        end
        tct_pkg::ST_ESTABLISHED: begin
          if (fa) begin
            if (fs) kind1 = tct_pkg::K_IGNORE;
            else begin
              nsq = rack_r; wr_sa = 1'b1;
              nak = rseq_r + ((slen_r > tct_pkg::HDR_LEN) ?
                    32'(slen_r - tct_pkg::HDR_LEN) : 32'd1);
            end
          end
        end
        tct_pkg::ST_FIN_OUT: begin
          if (!fa || ff) kind1 = tct_pkg::K_IGNORE;
          else if (rack_r != seq_p1) kind1 = tct_pkg::K_SEQ;
          else nst = tct_pkg::ST_FIN_ACKED;
        end
        tct_pkg::ST_FIN_ACKED: begin
          if (!fa || !ff) kind1 = tct_pkg::K_IGNORE;
          else if (rack_r != seq_p1) kind1 = tct_pkg::K_SEQ;
          else begin
            nsq = rack_r; nak = rseq_r + 32'd1; wr_sa = 1'b1;
            nst = tct_pkg::ST_CLOSED; is_hdr2 = 1'b1;
          end
        end
        default: ;
      endcase
      if (is_hdr2) begin
        kind2 = kind1;
        kind1 = tct_pkg::K_HEADER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < N; j++) st_r[j] <= tct_pkg::ST_UNUSED;
      ptr_r <= '0;
      hit_r <= 1'b0;
      free_v_r <= 1'b0;
      two_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        ptr_r <= '0;
        hit_r <= 1'b0;
        free_v_r <= 1'b0;
      end else if (cmd.step) begin
        ptr_r <= ptr_r + W'(1);
        if (match && !hit_r) begin
          hit_r <= 1'b1;
          hit_idx_r <= pi;
        end
        if (st_r[pi] == tct_pkg::ST_UNUSED && !free_v_r) begin
          free_v_r <= 1'b1;
          free_idx_r <= pi;
        end
      end
      if (cmd.exec) begin
        two_r <= is_hdr2;
        if (!res1_only) begin
          st_r[ei] <= nst;
          if (wr_tuple) begin
            la_r[ei] <= ila_r; lp_r[ei] <= ilp_r;
            ra_r[ei] <= ira_r; rp_r[ei] <= irp_r;
            wn_r[ei] <= nwn;
          end
          if (wr_sa) begin
            sq_r[ei] <= nsq;
            ak_r[ei] <= nak;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op; cs_r <= in_checksum_ok;
      ila_r <= in_local_addr; ilp_r <= in_local_port;
      ira_r <= in_remote_addr; irp_r <= in_remote_port;
      fl_r <= in_seg_flags; rseq_r <= in_rx_seq;
      rack_r <= in_rx_ack; slen_r <= in_segment_len;
    end
    if (cmd.out_ld1) begin
      out_kind <= kind1;
      out_conn_index <= res1_only ? 4'd0 : 4'(ei);
      out_conn_status <= res1_only ? tct_pkg::ST_UNUSED : nst;
      out_last <= !is_hdr2;
      if (kind1 == tct_pkg::K_HEADER) begin
        out_tx_seq <= nsq; out_tx_ack <= nak; out_tx_window <= nwn;
        out_tx_flags <= is_hdr2 ? tct_pkg::FL_ACK : fl_r;
      end else begin
        out_tx_seq <= '0; out_tx_ack <= '0; out_tx_window <= '0;
        out_tx_flags <= '0;
      end
      k2_r <= kind2; st2_r <= nst; i2_r <= ei;
    end
    if (cmd.out_ld2) begin
      out_kind <= k2_r;
      out_conn_index <= 4'(i2_r);
      out_conn_status <= st2_r;
      out_last <= 1'b1;
      out_tx_seq <= '0; out_tx_ack <= '0; out_tx_window <= '0;
      out_tx_flags <= '0;
    end
  end
endmodule

/* rtl/tct_ctrl.sv */
`timescale 1ns / 1ps
`include "tcp_client_connection_tracker_unit_defines.svh"
module tct_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output tct_pkg::cmd_t cmd,
  input  tct_pkg::sts_t sts
);
  tct_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tct_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      tct_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = tct_pkg::S_SCAN;
        end
      end
      tct_pkg::S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_done) state_nxt = tct_pkg::S_EXEC;
      end
      tct_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        cmd.out_ld1 = 1'b1;
        state_nxt = tct_pkg::S_OUT1;
      end
      tct_pkg::S_OUT1: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.two_res) begin
            cmd.out_ld2 = 1'b1;
            state_nxt = tct_pkg::S_OUT2;
          end else state_nxt = tct_pkg::S_IDLE;
        end
      end
      tct_pkg::S_OUT2: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = tct_pkg::S_IDLE;
      end
      default: state_nxt = tct_pkg::S_IDLE;
    endcase
  end

  `TCT_ASSERT_IMP(a_rdy_idle, in_ready, !out_valid, "ready while result pending")
  `TCT_ASSERT_NXT(a_load_scan, in_valid && in_ready, state_r == tct_pkg::S_SCAN,
                  "accepted item did not start scan")
  `TCT_ASSERT_NXT(a_exec_out, cmd.exec, out_valid, "result not shown after exec")
endmodule

/* rtl/tcp_client_connection_tracker_unit.sv */
`timescale 1ns / 1ps
// Flow: accept, entry-by-entry scan of all ConnEntries entries, exec, then result.
// A new item is taken only once the last result (and any second result) has been
//   accepted on the output side; the entry-by-entry tuple scan sets the pace.
// Reset (rst_n, synchronous): all entries unused, seq_base 1, initial_window 1.
// Tuple, seq, ack and window stores are not reset.
module tcp_client_connection_tracker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_local_addr,
  input  logic [15:0] in_local_port,
  input  logic [31:0] in_remote_addr,
  input  logic [15:0] in_remote_port,
  input  logic [5:0]  in_seg_flags,
  input  logic [31:0] in_rx_seq,
  input  logic [31:0] in_rx_ack,
  input  logic [15:0] in_segment_len,
  input  logic        in_checksum_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [3:0]  out_conn_index,
  output logic [31:0] out_tx_seq,
  output logic [31:0] out_tx_ack,
  output logic [15:0] out_tx_window,
  output logic [5:0]  out_tx_flags,
  output logic [2:0]  out_conn_status,
  output logic        out_last
);
  tct_pkg::cmd_t cmd;
  tct_pkg::sts_t sts;

  // controller: handshakes and step sequencing
  tct_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  // datapath: table, scan, decision, output register
  tct_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_index, .cfg_wdata,
    .in_op, .in_local_addr, .in_local_port, .in_remote_addr, .in_remote_port,
    .in_seg_flags, .in_rx_seq, .in_rx_ack, .in_segment_len, .in_checksum_ok,
    .out_kind, .out_conn_index, .out_tx_seq, .out_tx_ack, .out_tx_window,
    .out_tx_flags, .out_conn_status, .out_last
  );
endmodule
